// File: src/cle_pkg.sv
// Shared types and key codes for the console line editor.
package cle_pkg;

    // Default ring depth
    localparam int BUF_DEPTH_DEF = 128;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Key codes
    localparam logic [7:0] KEY_NUL   = 8'h00;
    localparam logic [7:0] KEY_EOF   = 8'h04;
    localparam logic [7:0] KEY_BS    = 8'h08;
    localparam logic [7:0] KEY_LF    = 8'h0a;
    localparam logic [7:0] KEY_CR    = 8'h0d;
    localparam logic [7:0] KEY_PLIST = 8'h10;
    localparam logic [7:0] KEY_KILL  = 8'h15;
    localparam logic [7:0] KEY_DEL   = 8'h7f;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_ECHO  = 3'd0,
        KIND_ERASE = 3'd1,
        KIND_PLIST = 3'd2,
        KIND_READ  = 3'd3,
        KIND_EOF   = 3'd4,
        KIND_EMPTY = 3'd5
    } kind_t;

    // Classified commands
    typedef enum logic [2:0] {
        CMD_READ   = 3'd0,
        CMD_PLIST  = 3'd1,
        CMD_KILL   = 3'd2,
        CMD_RUBOUT = 3'd3,
        CMD_STORE  = 3'd4
    } cmd_code_t;

    // One classified item as it travels from front to back
    typedef struct packed {
        cmd_code_t  code;
        logic [7:0] ch;
        logic       first;
        logic       ends_line;
    } cmd_t;

endpackage

// File: src/console_line_editor.sv
// Top level of the console line editor: front classifier, queue and back end.
//
//  channel   direction  handshake              fields
//  input     in         in_valid / in_ready    op, ch, first_of_read
//  result    out        out_valid / out_ready  kind, data_byte, erase_count, line_ready
//
// The front takes an item in any cycle the two-entry queue has room; zero bytes
// are dropped there. The back end runs one command at a time: a read waits for the
// registered ring read, a kill-line scans back its erased bytes, at most BUF_DEPTH - 1,
// one by one through the single read port of the ring, and all others finish in the
// idle state. The back end starts a command only when the result register is free,
// so a stalled result backs up into the queue and then the input.
// Reset clears the pointers and control; the ring itself is not cleared.
module console_line_editor import cle_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] ch,
    input  logic       first_of_read,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] data_byte,
    output logic [7:0] erase_count,
    output logic       line_ready
);

    logic q_ready;
    logic q_push;
    cmd_t q_cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_head;

    // Classify incoming items
    cle_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .ch            (ch),
        .first_of_read (first_of_read),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    // Decouple front and back
    cle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (q_head)
    );

    // Execute commands against the line ring
    cle_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd         (q_head),
        .cmd_pop     (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .erase_count (erase_count),
        .line_ready  (line_ready)
    );

endmodule

// File: src/cle_front.sv
// Front end: accepts input items and classifies them into commands.
module cle_front import cle_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] ch,
    input  logic       first_of_read,
    input  logic       q_ready,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic keep;

    // Accept whenever the queue has room; dropped items never enter it
    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready && keep;

    // Classify the item
    always_comb
    begin
        keep            = 1'b1;
        q_cmd.code      = CMD_STORE;
        q_cmd.ch        = ch;
        q_cmd.first     = first_of_read;
        q_cmd.ends_line = 1'b0;
        if (op)
        begin
            q_cmd.code = CMD_READ;
        end
        else
        begin
            case (ch)
                KEY_PLIST: q_cmd.code = CMD_PLIST;
                KEY_KILL:  q_cmd.code = CMD_KILL;
                KEY_NUL:   keep = 1'b0;
                default:
                begin
                    if (ch inside {KEY_BS, KEY_DEL})
                    begin
                        q_cmd.code = CMD_RUBOUT;
                    end
                    else
                    begin
                        // Map CR to LF; newline and end-of-file close the line
                        if (ch == KEY_CR)
                        begin
                            q_cmd.ch = KEY_LF;
                        end
                        q_cmd.ends_line = (ch == KEY_CR) || (ch == KEY_LF) ||
                                          (ch == KEY_EOF);
                    end
                end
            endcase
        end
    end

endmodule

// File: src/cle_queue.sv
// Short command queue between the front and back ends.
module cle_queue import cle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign push_ready = (cnt_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == LAST) ? '0 : rd_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/cle_back.sv
// Back end: runs commands against the line ring and registers each result.
module cle_back import cle_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] data_byte,
    output logic [7:0] erase_count,
    output logic       line_ready
);

    localparam int IDX_W = $clog2(BUF_DEPTH);
    localparam int CNT_W = $clog2(BUF_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUF_DEPTH - 1);

    // Pointer modulo twice the depth: ring index plus lap bit
    typedef struct packed {
        logic             wrap;
        logic [IDX_W-1:0] idx;
    } ptr_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RD   = 3'b010,
        ST_KILL = 3'b100
    } state_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        r = p;
        if (p.idx == IDX_LAST)
        begin
            r.idx  = '0;
            r.wrap = ~p.wrap;
        end
        else
        begin
            r.idx = p.idx + IDX_W'(1);
        end
        return r;
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        ptr_t r;
        r = p;
        if (p.idx == '0)
        begin
            r.idx  = IDX_LAST;
            r.wrap = ~p.wrap;
        end
        else
        begin
            r.idx = p.idx - IDX_W'(1);
        end
        return r;
    endfunction

    function automatic logic ring_full(input ptr_t e, input ptr_t r);
        return (e.idx == r.idx) && (e.wrap != r.wrap);
    endfunction

    state_t           state_reg, state_next;
    ptr_t             read_reg, read_next;
    ptr_t             commit_reg, commit_next;
    ptr_t             edit_reg, edit_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             first_reg, first_next;

    logic [7:0]       line_store_reg [BUF_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;

    logic             out_valid_reg;
    kind_t            kind_reg;
    logic [7:0]       data_reg;
    logic [7:0]       erase_reg;
    logic             ready_reg;

    logic             out_free;
    logic             emit;
    kind_t            emit_kind;
    logic [7:0]       emit_data;
    logic [CNT_W-1:0] emit_cnt;
    logic             emit_ready;
    logic [CNT_W-1:0] cnt_inc;
    ptr_t             edit_dec;
    ptr_t             edit_dec2;
    ptr_t             edit_inc;

    assign out_free  = !out_valid_reg || out_ready;
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign edit_dec  = ptr_dec(edit_reg);
    assign edit_dec2 = ptr_dec(edit_dec);
    assign edit_inc  = ptr_inc(edit_reg);

    // Command sequencer
    always_comb
    begin
        state_next  = state_reg;
        read_next   = read_reg;
        commit_next = commit_reg;
        edit_next   = edit_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        rd_addr     = read_reg.idx;
        mem_we      = 1'b0;
        mem_waddr   = edit_reg.idx;
        mem_wdata   = cmd.ch;
        cmd_pop     = 1'b0;
        emit        = 1'b0;
        emit_kind   = KIND_ECHO;
        emit_data   = '0;
        emit_cnt    = '0;
        emit_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.code)
                        CMD_READ:
                        begin
                            if (read_reg == commit_reg)
                            begin
                                emit      = 1'b1;
                                emit_kind = KIND_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = read_reg.idx;
                                first_next = cmd.first;
                                state_next = ST_RD;
                            end
                        end
                        CMD_PLIST:
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_PLIST;
                        end
                        CMD_KILL:
                        begin
                            // Start the backward scan at the last typed byte
                            if (edit_reg != commit_reg)
                            begin
                                rd_addr    = edit_dec.idx;
                                cnt_next   = '0;
                                state_next = ST_KILL;
                            end
                        end
                        CMD_RUBOUT:
                        begin
                            if (edit_reg != commit_reg)
                            begin
                                edit_next = edit_dec;
                                emit      = 1'b1;
                                emit_kind = KIND_ERASE;
                                emit_cnt  = CNT_W'(1);
                            end
                        end
                        CMD_STORE:
                        begin
                            // Drop the byte when the ring is full
                            if (!ring_full(edit_reg, read_reg))
                            begin
                                mem_we    = 1'b1;
                                edit_next = edit_inc;
                                emit      = 1'b1;
                                emit_kind = KIND_ECHO;
                                emit_data = cmd.ch;
                                if (cmd.ends_line || ring_full(edit_inc, read_reg))
                                begin
                                    commit_next = edit_inc;
                                    emit_ready  = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                // End-of-file stays in place unless it opens the read
                state_next = ST_IDLE;
                emit       = 1'b1;
                if (rd_data_reg == KEY_EOF)
                begin
                    emit_kind = KIND_EOF;
                    if (first_reg)
                    begin
                        read_next = ptr_inc(read_reg);
                    end
                end
                else
                begin
                    emit_kind = KIND_READ;
                    emit_data = rd_data_reg;
                    read_next = ptr_inc(read_reg);
                end
            end
            ST_KILL:
            begin
                // One byte a cycle: stop at a line start or the committed end
                if (rd_data_reg == KEY_LF)
                begin
                    state_next = ST_IDLE;
                    if (cnt_reg != '0)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_ERASE;
                        emit_cnt  = cnt_reg;
                    end
                end
                else
                begin
                    edit_next = edit_dec;
                    cnt_next  = cnt_inc;
                    if (edit_dec == commit_reg)
                    begin
                        state_next = ST_IDLE;
                        emit       = 1'b1;
                        emit_kind  = KIND_ERASE;
                        emit_cnt   = cnt_inc;
                    end
                    else
                    begin
                        rd_addr = edit_dec2.idx;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            read_reg      <= '0;
            commit_reg    <= '0;
            edit_reg      <= '0;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            read_reg   <= read_next;
            commit_reg <= commit_next;
            edit_reg   <= edit_next;
            cnt_reg    <= cnt_next;
            first_reg  <= first_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result register, saturating the erase count
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= emit_kind;
            data_reg  <= emit_data;
            erase_reg <= (int'(emit_cnt) > 255) ? 8'hff : 8'(emit_cnt);
            ready_reg <= emit_ready;
        end
    end

    // Line ring: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_store_reg[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= line_store_reg[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign data_byte   = data_reg;
    assign erase_count = erase_reg;
    assign line_ready  = ready_reg;

endmodule
